### rtl/gqlay_pkg.sv
`default_nettype none
package gqlay_pkg;

  localparam int OP_W       = 2;
  localparam int CODE_W     = 8;
  localparam int TEXEL_W    = 12;
  localparam int GDIM_W     = 8;
  localparam int OFF_W      = 8;
  localparam int LH_W       = 8;
  localparam int ATLAS_W    = 13;
  localparam int POS_W      = 16;
  localparam int SUM_W      = 18;
  localparam int TEX_W      = 17;
  localparam int FRAC_W     = 16;
  localparam int QN_W       = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int DIV_N      = 4;

  localparam int GLYPH_SLOTS_DEF = 256;
  localparam int MAX_QUADS_DEF   = 4096;

  localparam logic [TEX_W-1:0] ONE_Q16 = TEX_W'(1) << FRAC_W;

  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_CHAR  = 2'd1;
  localparam logic [OP_W-1:0] OP_START = 2'd2;

  localparam logic [CODE_W-1:0] CODE_TAB     = 8'd9;
  localparam logic [CODE_W-1:0] CODE_NEWLINE = 8'd10;
  localparam logic [CODE_W-1:0] CODE_SPACE   = 8'd32;

  localparam logic [CFG_IDX_W-1:0] REG_LINE_PITCH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ATLAS_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FLIP_V       = 2'd3;

  localparam int DIV_U0 = 0;
  localparam int DIV_U1 = 1;
  localparam int DIV_V0 = 2;
  localparam int DIV_V1 = 3;

  typedef struct packed {
    logic [TEXEL_W-1:0]      gx;
    logic [TEXEL_W-1:0]      gy;
    logic [GDIM_W-1:0]       gw;
    logic [GDIM_W-1:0]       gh;
    logic signed [OFF_W-1:0] xoff;
    logic signed [OFF_W-1:0] yoff;
    logic [GDIM_W-1:0]       adv;
  } glyph_t;

  localparam int GLYPH_W = $bits(glyph_t);

  typedef struct packed {
    logic               start;
    logic [ATLAS_W-1:0] num;
    logic [ATLAS_W-1:0] den;
  } div_req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DIVIDE
  } state_t;

endpackage
`default_nettype wire

### rtl/gqlay_if.sv
`default_nettype none
interface gqlay_in_if;
  import gqlay_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [OP_W-1:0]         op;
  logic [CODE_W-1:0]       code;
  logic [TEXEL_W-1:0]      glyph_x;
  logic [TEXEL_W-1:0]      glyph_y;
  logic [GDIM_W-1:0]       glyph_w;
  logic [GDIM_W-1:0]       glyph_h;
  logic signed [OFF_W-1:0] glyph_xoff;
  logic signed [OFF_W-1:0] glyph_yoff;
  logic [GDIM_W-1:0]       glyph_adv;
  modport source (output valid, op, code, glyph_x, glyph_y, glyph_w, glyph_h,
                  glyph_xoff, glyph_yoff, glyph_adv, input ready);
  modport sink (input valid, op, code, glyph_x, glyph_y, glyph_w, glyph_h,
                glyph_xoff, glyph_yoff, glyph_adv, output ready);
endinterface

interface gqlay_out_if;
  import gqlay_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [QN_W-1:0]         quad_number;
  logic signed [POS_W-1:0] left;
  logic signed [POS_W-1:0] top;
  logic signed [POS_W-1:0] right;
  logic signed [POS_W-1:0] bottom;
  logic [TEX_W-1:0]        tex_u0;
  logic [TEX_W-1:0]        tex_u1;
  logic [TEX_W-1:0]        tex_v0;
  logic [TEX_W-1:0]        tex_v1;
  modport source (output valid, quad_number, left, top, right, bottom,
                  tex_u0, tex_u1, tex_v0, tex_v1, input ready);
  modport sink (input valid, quad_number, left, top, right, bottom,
                tex_u0, tex_u1, tex_v0, tex_v1, output ready);
endinterface

interface gqlay_cfg_if;
  import gqlay_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/gqlay_ram.sv
`default_nettype none
module gqlay_ram #(
  parameter int WIDTH = gqlay_pkg::GLYPH_W,
  parameter int DEPTH = gqlay_pkg::GLYPH_SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

### rtl/gqlay_div.sv
`default_nettype none
module gqlay_div (
  input  logic                                clk,
  input  logic                                rst,
  input  gqlay_pkg::div_req_t                 req,
  output logic                                busy,
  output logic [gqlay_pkg::TEX_W-1:0]         quot
);
  import gqlay_pkg::*;

  localparam int DIVD_W = ATLAS_W + FRAC_W + 1;
  localparam int CNT_W  = $clog2(TEX_W + 1);

  logic [DIVD_W-1:0]  dividend;
  logic [ATLAS_W-1:0] den;
  logic [ATLAS_W-1:0] rem;
  logic [TEX_W-1:0]   sh;
  logic [CNT_W-1:0]   cnt;
  logic [ATLAS_W:0]   trial;
  logic [ATLAS_W:0]   diff;
  logic               ge;
  logic               clamp;

  // num >= den (den zero included) clamps the quotient to 1.0
  assign clamp    = req.num >= req.den;
  assign dividend = {1'b0, req.num, FRAC_W'(0)} + DIVD_W'(req.den >> 1);
  assign trial    = {rem, sh[TEX_W-1]};
  assign diff     = trial - {1'b0, den};
  assign ge       = trial >= {1'b0, den};
  assign busy     = cnt != '0;
  assign quot     = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (req.start) begin
      cnt <= clamp ? '0 : CNT_W'(TEX_W);
    end else if (busy) begin
      cnt <= cnt - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      den <= req.den;
      rem <= dividend[DIVD_W-1:TEX_W];
      sh  <= clamp ? ONE_Q16 : dividend[TEX_W-1:0];
    end else if (busy) begin
      rem <= ge ? diff[ATLAS_W-1:0] : trial[ATLAS_W-1:0];
      sh  <= {sh[TEX_W-2:0], ge};
    end
  end

endmodule
`default_nettype wire

### rtl/glyph_quad_layout.sv
`default_nettype none
// Text quad layout from a loaded glyph table. Load, start, newline and
// out-of-table codes never leave the idle state; tab and zero-width
// glyphs also pass one glyph table read; a glyph that emits a quad then
// waits on the four bit-serial dividers that produce the 17-bit texture
// coordinates one quotient bit per cycle, clamping at 1.0. A finished
// quad sits in the output register while the next item is taken; a quad
// is held back only if the previous one is still waiting there. The
// glyph table has no reset; reading an unloaded slot gives undefined
// metrics.
module glyph_quad_layout #(
  parameter int GLYPH_SLOTS = gqlay_pkg::GLYPH_SLOTS_DEF,
  parameter int MAX_QUADS   = gqlay_pkg::MAX_QUADS_DEF
) (
  input logic         clk,
  input logic         rst,
  gqlay_cfg_if.sink   cfg,
  gqlay_in_if.sink    chars,
  gqlay_out_if.source quads
);
  import gqlay_pkg::*;

  localparam int AW         = $clog2(GLYPH_SLOTS);
  localparam int QCW        = $clog2(MAX_QUADS + 1);
  localparam int CODE_EXT_W = CODE_W + 1;
  localparam int ADV_W      = GDIM_W + 2;

  function automatic logic signed [POS_W-1:0] sat16(input logic signed [SUM_W-1:0] v);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    hi = SUM_W'(32767);
    lo = -SUM_W'(32768);
    if (v > hi) begin
      return POS_W'(hi);
    end else if (v < lo) begin
      return POS_W'(lo);
    end
    return v[POS_W-1:0];
  endfunction

  state_t state, state_next;

  logic [LH_W-1:0]    line_pitch;
  logic [ATLAS_W-1:0] atlas_width;
  logic [ATLAS_W-1:0] atlas_height;
  logic               flip_v;

  logic signed [POS_W-1:0] pen_x, pen_x_next;
  logic signed [POS_W-1:0] pen_y, pen_y_next;
  logic [QCW-1:0]          qcnt, qcnt_next;
  logic                    is_tab, is_tab_next;

  logic [QN_W-1:0]         pend_qnum;
  logic signed [POS_W-1:0] pend_l, pend_t, pend_r, pend_b;

  logic                    out_valid;
  logic [QN_W-1:0]         out_qnum;
  logic signed [POS_W-1:0] out_l, out_t, out_r, out_b;
  logic [TEX_W-1:0]        out_u0, out_u1, out_v0, out_v1;

  logic          accept, code_ok, ram_we, ram_re, div_start, pend_load, emit;
  logic [AW-1:0] ram_raddr;
  glyph_t        wr_glyph, rd;

  logic [ADV_W-1:0]        adv_eff;
  logic signed [SUM_W-1:0] l_full, t_full, r_full, b_full;

  div_req_t         div_req [DIV_N];
  logic [DIV_N-1:0] div_busy;
  logic [TEX_W-1:0] div_q [DIV_N];

  assign chars.ready = state == ST_IDLE;
  assign cfg.ready   = 1'b1;
  assign accept      = chars.valid && chars.ready;
  assign code_ok     = {1'b0, chars.code} < CODE_EXT_W'(GLYPH_SLOTS);
  assign ram_raddr   = (chars.code == CODE_TAB) ? AW'(CODE_SPACE) : chars.code[AW-1:0];

  assign wr_glyph = '{gx: chars.glyph_x, gy: chars.glyph_y, gw: chars.glyph_w,
                      gh: chars.glyph_h, xoff: chars.glyph_xoff,
                      yoff: chars.glyph_yoff, adv: chars.glyph_adv};

  gqlay_ram #(
    .WIDTH (GLYPH_W),
    .DEPTH (GLYPH_SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (chars.code[AW-1:0]),
    .wdata (wr_glyph),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  assign adv_eff = is_tab ? {rd.adv, 2'b00} : ADV_W'(rd.adv);
  assign l_full  = SUM_W'(pen_x) + SUM_W'(rd.xoff);
  assign t_full  = SUM_W'(pen_y) + SUM_W'(rd.yoff);
  assign r_full  = l_full + $signed(SUM_W'(rd.gw));
  assign b_full  = t_full + $signed(SUM_W'(rd.gh));

  always_comb begin
    div_req[DIV_U0] = '{start: div_start, num: ATLAS_W'(rd.gx), den: atlas_width};
    div_req[DIV_U1] = '{start: div_start, num: ATLAS_W'(rd.gx) + ATLAS_W'(rd.gw),
                        den: atlas_width};
    div_req[DIV_V0] = '{start: div_start, num: ATLAS_W'(rd.gy), den: atlas_height};
    div_req[DIV_V1] = '{start: div_start, num: ATLAS_W'(rd.gy) + ATLAS_W'(rd.gh),
                        den: atlas_height};
  end

  for (genvar i = 0; i < DIV_N; i++) begin : g_div
    gqlay_div u_div (
      .clk  (clk),
      .rst  (rst),
      .req  (div_req[i]),
      .busy (div_busy[i]),
      .quot (div_q[i])
    );
  end

  always_comb begin
    state_next  = state;
    pen_x_next  = pen_x;
    pen_y_next  = pen_y;
    qcnt_next   = qcnt;
    is_tab_next = is_tab;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    div_start   = 1'b0;
    pend_load   = 1'b0;
    emit        = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          priority if (chars.op == OP_LOAD) begin
            ram_we = code_ok;
          end else if (chars.op == OP_START) begin
            pen_x_next = '0;
            pen_y_next = '0;
            qcnt_next  = '0;
          end else if (chars.op == OP_CHAR) begin
            priority if (chars.code == CODE_NEWLINE) begin
              pen_x_next = '0;
              pen_y_next = sat16(SUM_W'(pen_y) + $signed(SUM_W'(line_pitch)));
            end else if (chars.code == CODE_TAB || code_ok) begin
              ram_re      = 1'b1;
              is_tab_next = chars.code == CODE_TAB;
              state_next  = ST_LOOKUP;
            end else begin
            end
          end else begin
          end
        end
      end
      ST_LOOKUP: begin
        pen_x_next = sat16(SUM_W'(pen_x) + $signed(SUM_W'(adv_eff)));
        state_next = ST_IDLE;
        if (!is_tab && rd.gw != '0 && qcnt < QCW'(MAX_QUADS)) begin
          div_start  = 1'b1;
          pend_load  = 1'b1;
          qcnt_next  = qcnt + QCW'(1);
          state_next = ST_DIVIDE;
        end
      end
      ST_DIVIDE: begin
        if (div_busy == '0 && (!out_valid || quads.ready)) begin
          emit       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pen_x  <= '0;
      pen_y  <= '0;
      qcnt   <= '0;
      is_tab <= 1'b0;
    end else begin
      state  <= state_next;
      pen_x  <= pen_x_next;
      pen_y  <= pen_y_next;
      qcnt   <= qcnt_next;
      is_tab <= is_tab_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_pitch   <= LH_W'(16);
      atlas_width  <= ATLAS_W'(256);
      atlas_height <= ATLAS_W'(256);
      flip_v       <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        REG_LINE_PITCH:   line_pitch   <= cfg.data[LH_W-1:0];
        REG_ATLAS_WIDTH:  atlas_width  <= cfg.data[ATLAS_W-1:0];
        REG_ATLAS_HEIGHT: atlas_height <= cfg.data[ATLAS_W-1:0];
        REG_FLIP_V:       flip_v       <= cfg.data[0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pend_load) begin
      pend_qnum <= QN_W'(qcnt);
      pend_l    <= sat16(l_full);
      pend_t    <= sat16(t_full);
      pend_r    <= sat16(r_full);
      pend_b    <= sat16(b_full);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (quads.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_qnum <= pend_qnum;
      out_l    <= pend_l;
      out_t    <= pend_t;
      out_r    <= pend_r;
      out_b    <= pend_b;
      out_u0   <= div_q[DIV_U0];
      out_u1   <= div_q[DIV_U1];
      out_v0   <= flip_v ? ONE_Q16 - div_q[DIV_V0] : div_q[DIV_V0];
      out_v1   <= flip_v ? ONE_Q16 - div_q[DIV_V1] : div_q[DIV_V1];
    end
  end

  assign quads.valid       = out_valid;
  assign quads.quad_number = out_qnum;
  assign quads.left        = out_l;
  assign quads.top         = out_t;
  assign quads.right       = out_r;
  assign quads.bottom      = out_b;
  assign quads.tex_u0      = out_u0;
  assign quads.tex_u1      = out_u1;
  assign quads.tex_v0      = out_v0;
  assign quads.tex_v1      = out_v1;

  a_div_only_in_divide: assert property (@(posedge clk) disable iff (rst)
    (state != ST_DIVIDE) |-> (div_busy == '0))
    else $error("divider busy outside divide state");

  a_emit_shows_quad: assert property (@(posedge clk) disable iff (rst)
    emit |=> (quads.valid && quads.quad_number == $past(pend_qnum)))
    else $error("emitted quad not presented");

  a_quad_limit: assert property (@(posedge clk) disable iff (rst)
    qcnt <= QCW'(MAX_QUADS))
    else $error("quad counter beyond limit");

endmodule
`default_nettype wire

### test/tb_glyph_quad_layout.sv
`timescale 1ns / 1ps
module tb_glyph_quad_layout;
  import gqlay_pkg::*;

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int TAB_SPACES  = 4;
  localparam int CYCLE_LIMIT = 1_200_000;
  localparam int SETTLE_CYCLES = 30;

  typedef struct {
    logic [OP_W-1:0]         op;
    logic [CODE_W-1:0]       code;
    logic [TEXEL_W-1:0]      gx;
    logic [TEXEL_W-1:0]      gy;
    logic [GDIM_W-1:0]       gw;
    logic [GDIM_W-1:0]       gh;
    logic signed [OFF_W-1:0] xoff;
    logic signed [OFF_W-1:0] yoff;
    logic [GDIM_W-1:0]       adv;
  } char_item_t;

  typedef struct {
    logic [QN_W-1:0]         qn;
    logic signed [POS_W-1:0] left;
    logic signed [POS_W-1:0] top;
    logic signed [POS_W-1:0] right;
    logic signed [POS_W-1:0] bottom;
    logic [TEX_W-1:0]        u0;
    logic [TEX_W-1:0]        u1;
    logic [TEX_W-1:0]        v0;
    logic [TEX_W-1:0]        v1;
  } quad_t;

  logic clk;
  logic rst;

  gqlay_cfg_if cfg_if ();
  gqlay_in_if  chars_if ();
  gqlay_out_if quads_if ();

  glyph_quad_layout u_dut (
    .clk   (clk),
    .rst   (rst),
    .cfg   (cfg_if),
    .chars (chars_if),
    .quads (quads_if)
  );

  // layout predictor state
  glyph_t           glyph_mem [GLYPH_SLOTS_DEF];
  int               pen_x;
  int               pen_y;
  int               quads_in_text;
  logic [LH_W-1:0]    line_pitch;
  logic [ATLAS_W-1:0] atlas_w;
  logic [ATLAS_W-1:0] atlas_h;
  logic               flip;

  quad_t      quads_due [$];
  char_item_t text_stream [$];
  char_item_t on_bus;
  bit         loaded [GLYPH_SLOTS_DEF];
  int         loaded_codes [$];
  int         sent;
  int         taken;
  int         burst_left;
  int         gap_left;
  int         stall_mode;
  int         stall_cyc;
  int         mismatches;
  int         cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int sat16(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic logic [TEX_W-1:0] to_q16(input int num, input logic [ATLAS_W-1:0] den);
    longint q;
    if (den == 0) return ONE_Q16;
    q = ((longint'(num) << FRAC_W) + longint'(den / 2)) / longint'(den);
    return (q > longint'(ONE_Q16)) ? ONE_Q16 : TEX_W'(q);
  endfunction

  function automatic void lay_out_char(input char_item_t it);
    glyph_t g;
    int     l;
    int     t;
    int     r;
    int     b;
    quad_t  q;
    case (it.op)
      OP_LOAD: begin
        g.gx = it.gx; g.gy = it.gy; g.gw = it.gw; g.gh = it.gh;
        g.xoff = it.xoff; g.yoff = it.yoff; g.adv = it.adv;
        glyph_mem[it.code] = g;
      end
      OP_START: begin
        pen_x = 0;
        pen_y = 0;
        quads_in_text = 0;
      end
      OP_CHAR: begin
        if (it.code == CODE_NEWLINE) begin
          pen_x = 0;
          pen_y = sat16(pen_y + int'(line_pitch));
        end else if (it.code == CODE_TAB) begin
          pen_x = sat16(pen_x + TAB_SPACES * int'(glyph_mem[CODE_SPACE].adv));
        end else begin
          g = glyph_mem[it.code];
          if (g.gw == 0) begin
            pen_x = sat16(pen_x + int'(g.adv));
          end else begin
            l = pen_x + int'($signed(g.xoff));
            t = pen_y + int'($signed(g.yoff));
            r = l + int'(g.gw);
            b = t + int'(g.gh);
            pen_x = sat16(pen_x + int'(g.adv));
            if (quads_in_text < MAX_QUADS_DEF) begin
              q.qn     = QN_W'(quads_in_text);
              q.left   = POS_W'(sat16(l));
              q.top    = POS_W'(sat16(t));
              q.right  = POS_W'(sat16(r));
              q.bottom = POS_W'(sat16(b));
              q.u0 = to_q16(int'(g.gx), atlas_w);
              q.u1 = to_q16(int'(g.gx) + int'(g.gw), atlas_w);
              q.v0 = to_q16(int'(g.gy), atlas_h);
              q.v1 = to_q16(int'(g.gy) + int'(g.gh), atlas_h);
              if (flip) begin
                q.v0 = ONE_Q16 - q.v0;
                q.v1 = ONE_Q16 - q.v1;
              end
              quads_due.push_back(q);
              quads_in_text++;
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // driver
  always @(posedge clk) begin
    if (rst) begin
      chars_if.valid <= 1'b0;
    end else begin
      if (chars_if.valid && chars_if.ready) begin
        lay_out_char(on_bus);
        taken++;
      end
      if (!chars_if.valid || chars_if.ready) begin
        if (gap_left > 0 || text_stream.size() == 0) begin
          if (gap_left > 0) gap_left--;
          chars_if.valid <= 1'b0;
        end else begin
          on_bus = text_stream.pop_front();
          chars_if.valid      <= 1'b1;
          chars_if.op         <= on_bus.op;
          chars_if.code       <= on_bus.code;
          chars_if.glyph_x    <= on_bus.gx;
          chars_if.glyph_y    <= on_bus.gy;
          chars_if.glyph_w    <= on_bus.gw;
          chars_if.glyph_h    <= on_bus.gh;
          chars_if.glyph_xoff <= on_bus.xoff;
          chars_if.glyph_yoff <= on_bus.yoff;
          chars_if.glyph_adv  <= on_bus.adv;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = ($urandom_range(5) == 0) ? $urandom_range(80, 30) : $urandom_range(24, 1);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(12, 1);
          end
        end
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      quads_if.ready <= 1'b0;
    end else begin
      stall_cyc++;
      if (stall_cyc >= 200) begin
        stall_cyc  = 0;
        stall_mode = $urandom_range(3);
      end
      case (stall_mode)
        0: quads_if.ready <= 1'b1;
        1: quads_if.ready <= (stall_cyc % 5 != 0) && (stall_cyc % 7 != 3);
        2: quads_if.ready <= 1'($urandom_range(1));
        default: quads_if.ready <= (stall_cyc % 64) >= 30;
      endcase
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("quad %s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // monitor
  always @(posedge clk) begin
    if (!rst && quads_if.valid && quads_if.ready) begin
      if (quads_due.size() == 0) begin
        $error("quad %0d arrived with none outstanding", quads_if.quad_number);
        mismatches++;
      end else begin
        check_field("quad_number", longint'(quads_due[0].qn),
                    longint'(quads_if.quad_number));
        check_field("left", longint'(quads_due[0].left), longint'(quads_if.left));
        check_field("top", longint'(quads_due[0].top), longint'(quads_if.top));
        check_field("right", longint'(quads_due[0].right), longint'(quads_if.right));
        check_field("bottom", longint'(quads_due[0].bottom), longint'(quads_if.bottom));
        check_field("tex_u0", longint'(quads_due[0].u0), longint'(quads_if.tex_u0));
        check_field("tex_u1", longint'(quads_due[0].u1), longint'(quads_if.tex_u1));
        check_field("tex_v0", longint'(quads_due[0].v0), longint'(quads_if.tex_v0));
        check_field("tex_v1", longint'(quads_due[0].v1), longint'(quads_if.tex_v1));
        void'(quads_due.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic int pick(input int lo, input int hi);
    int r;
    r = $urandom_range(7);
    if (r == 0) return lo;
    if (r == 1) return hi;
    return lo + int'($urandom_range(hi - lo));
  endfunction

  function automatic char_item_t junk_item(input logic [OP_W-1:0] op, input int code);
    char_item_t it;
    it.op   = op;
    it.code = CODE_W'(code);
    it.gx   = TEXEL_W'($urandom);
    it.gy   = TEXEL_W'($urandom);
    it.gw   = GDIM_W'($urandom);
    it.gh   = GDIM_W'($urandom);
    it.xoff = OFF_W'($urandom);
    it.yoff = OFF_W'($urandom);
    it.adv  = GDIM_W'($urandom);
    return it;
  endfunction

  function automatic char_item_t load_item(input int code, input int gx, input int gy,
                                           input int gw, input int gh, input int xo,
                                           input int yo, input int adv);
    char_item_t it;
    it.op   = OP_LOAD;
    it.code = CODE_W'(code);
    it.gx   = TEXEL_W'(gx);
    it.gy   = TEXEL_W'(gy);
    it.gw   = GDIM_W'(gw);
    it.gh   = GDIM_W'(gh);
    it.xoff = OFF_W'(xo);
    it.yoff = OFF_W'(yo);
    it.adv  = GDIM_W'(adv);
    return it;
  endfunction

  function automatic char_item_t random_glyph();
    int slot;
    slot = ($urandom_range(5) == 0) ? pick(int'(CODE_TAB), int'(CODE_SPACE))
                                    : $urandom_range(255);
    return load_item(slot, pick(0, 4095), pick(0, 4095),
                     ($urandom_range(4) == 0) ? 0 : pick(1, 255), pick(0, 255),
                     pick(-128, 127), pick(-128, 127), pick(0, 255));
  endfunction

  function automatic void send(input char_item_t it);
    if (it.op == OP_LOAD && !loaded[it.code]) begin
      loaded[it.code] = 1'b1;
      loaded_codes.push_back(int'(it.code));
    end
    text_stream.push_back(it);
    sent++;
  endfunction

  function automatic void send_char(input int code);
    send(junk_item(OP_CHAR, code));
  endfunction

  function automatic int any_glyph();
    return loaded_codes[$urandom_range(loaded_codes.size() - 1)];
  endfunction

  task automatic settle();
    while (taken != sent || quads_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      REG_LINE_PITCH:   line_pitch = LH_W'(val);
      REG_ATLAS_WIDTH:  atlas_w = ATLAS_W'(val);
      REG_ATLAS_HEIGHT: atlas_h = ATLAS_W'(val);
      REG_FLIP_V:       flip = val[0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input int lh, input int aw, input int ah, input int fv);
    write_reg(REG_LINE_PITCH, lh);
    write_reg(REG_ATLAS_WIDTH, aw);
    write_reg(REG_ATLAS_HEIGHT, ah);
    write_reg(REG_FLIP_V, fv);
  endtask

  task automatic random_texts(input int n_items);
    int made;
    int r;
    int len;
    made = 0;
    repeat (10) send(random_glyph());
    while (made < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        send(random_glyph());
        made++;
      end else if (r < 12) begin
        send(junk_item(OP_UNUSED, $urandom_range(255)));
      end else if (r < 16) begin
        send(junk_item(OP_START, $urandom_range(255)));
        made++;
      end else begin
        if ($urandom_range(9) < 7) begin
          send(junk_item(OP_START, $urandom_range(255)));
          made++;
        end
        len = $urandom_range(30, 1);
        repeat (len) begin
          r = $urandom_range(99);
          if (r < 10) send_char(int'(CODE_NEWLINE));
          else if (r < 16) send_char(int'(CODE_TAB));
          else send_char(any_glyph());
          made++;
        end
      end
    end
    settle();
  endtask

  initial begin
    rst = 1'b1;
    cfg_if.valid = 1'b0;
    cfg_if.index = '0;
    cfg_if.data  = '0;
    chars_if.valid = 1'b0;
    chars_if.op = '0;
    chars_if.code = '0;
    chars_if.glyph_x = '0;
    chars_if.glyph_y = '0;
    chars_if.glyph_w = '0;
    chars_if.glyph_h = '0;
    chars_if.glyph_xoff = '0;
    chars_if.glyph_yoff = '0;
    chars_if.glyph_adv = '0;
    quads_if.ready = 1'b0;
    pen_x = 0;
    pen_y = 0;
    quads_in_text = 0;
    line_pitch = 8'd16;
    atlas_w = 13'd256;
    atlas_h = 13'd256;
    flip = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, control codes over loaded slots, zero width, unused op
    send(load_item(int'(CODE_SPACE), 0, 0, 0, 0, 0, 0, 8));
    send(load_item(65, 0, 0, 255, 255, -128, -128, 255));
    send(load_item(255, 4095, 4095, 255, 255, 127, 127, 0));
    send(load_item(int'(CODE_TAB), 100, 100, 10, 10, 1, 1, 50));
    send(load_item(int'(CODE_NEWLINE), 200, 200, 10, 10, 1, 1, 50));
    send(load_item(0, 4095, 0, 1, 1, 0, 0, 1));
    send(load_item(66, 17, 33, 0, 5, 3, 3, 0));
    send_char(65);
    send_char(255);
    send_char(0);
    send_char(int'(CODE_SPACE));
    send_char(int'(CODE_TAB));
    send_char(65);
    send_char(int'(CODE_NEWLINE));
    send_char(66);
    send_char(65);
    send(junk_item(OP_UNUSED, 65));
    send(junk_item(OP_START, 0));
    send_char(65);
    send_char(255);
    send_char(int'(CODE_NEWLINE));
    send_char(int'(CODE_NEWLINE));
    send_char(0);
    settle();

    set_regs(13'h1F00, 1, 1, 13'h1FFF);
    random_texts(25);
    set_regs(255, 4096, 4096, 0);
    random_texts(25);
    set_regs(13'h0A37, 0, 0, 1);
    random_texts(25);
    set_regs(8, 8191, 3, 13'h0002);
    random_texts(25);
    set_regs($urandom_range(8191), $urandom_range(4096, 1), $urandom_range(4096, 1),
             $urandom_range(1));
    random_texts(25);
    set_regs($urandom_range(8191), $urandom_range(8191), $urandom_range(8191),
             $urandom_range(1));
    random_texts(25);

    // pen y saturation
    set_regs(13'h1FFF, 300, 700, 1);
    send(junk_item(OP_START, 0));
    for (int i = 0; i < 140; i++) begin
      send_char(int'(CODE_NEWLINE));
      if (i % 20 == 19) send_char(65);
    end
    send_char(255);
    settle();

    // pen x saturation over one long text
    set_regs(16, 1, 1, 0);
    send(load_item(200, 3, 2, 4, 6, -5, 2, 255));
    send(load_item(201, 7, 7, 0, 0, 0, 0, 3));
    send(junk_item(OP_START, 0));
    repeat (132) send_char(200);
    send_char(201);
    send_char(200);
    send(junk_item(OP_START, 0));
    send_char(200);
    send_char(200);
    settle();

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### glyph_quad_layout.f
rtl/gqlay_pkg.sv
rtl/gqlay_if.sv
rtl/gqlay_ram.sv
rtl/gqlay_div.sv
rtl/glyph_quad_layout.sv
test/tb_glyph_quad_layout.sv
